[rtl/pwmpde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwmpde_pkg
// Shared types and constants of the PWM period / duty encoder.
// ============================================================================
package pwmpde_pkg;

    localparam int unsigned WIDTH_MAX = 10000;
    localparam int unsigned HALF_W    = WIDTH_MAX / 2;

    localparam int FREQ_W  = 32;
    localparam int RATE_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int PER_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int TOP_W   = 6;

    // divider: numerator clock + freq, denominator 2 * freq
    localparam int NUM_W      = RATE_W + 1;
    localparam int QUO_W      = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;

    localparam logic [SHIFT_W-1:0] FORCE_SHIFT = SHIFT_W'(8);
    localparam logic [QUO_W-1:0]   FORCE_DIV   = QUO_W'(32'hf00);
    localparam logic [PER_W-1:0]   WORD_MAX    = PER_W'(16'hffff);

    // duty scaling
    localparam int X_W = DUTY_W + (1 << SHIFT_W) - 1;
    localparam longint unsigned SAT_NUM = (64'd1 << PER_W) * 64'(WIDTH_MAX);
    localparam logic [X_W-1:0] CLIP_X = X_W'(SAT_NUM - 64'(HALF_W));
    localparam int Y_W = $clog2(SAT_NUM);
    localparam int RECIP_SH = 40;
    localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / 64'(WIDTH_MAX);
    localparam int M_W = $clog2(RECIP_L + 1);
    localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP_L);
    localparam int PROD_W = Y_W + M_W;

    localparam logic [RATE_W-1:0] CLK_RATE_RST = RATE_W'(156000000);

    // stream packing
    localparam int IN_TDATA_W  = ((FREQ_W + DUTY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PER_W + SHIFT_W + PER_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 4;
    localparam int U_CMODE = 0;
    localparam int U_DERR  = 1;
    localparam int U_FERR  = 2;
    localparam int U_CLIP  = 3;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              freq_zero;
    } t_side;

    typedef struct packed {
        logic [PER_W-1:0]   period;
        logic [SHIFT_W-1:0] shift;
        logic               cmode;
        logic [DUTY_W-1:0]  duty;
        logic               freq_zero;
    } t_per;

    typedef struct packed {
        logic [PER_W-1:0]   period;
        logic [SHIFT_W-1:0] shift;
        logic [PER_W-1:0]   dword;
        logic               cmode;
        logic               derr;
        logic               ferr;
        logic               clip;
    } t_res;

endpackage
`default_nettype wire

[rtl/pwmpde_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwmpde_div
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// ============================================================================
module pwmpde_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [pwmpde_pkg::NUM_W-1:0]  i_num,
    input  wire logic [pwmpde_pkg::NUM_W-1:0]  i_den,
    input  wire pwmpde_pkg::t_side             i_side,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [pwmpde_pkg::QUO_W-1:0]       o_quo,
    output pwmpde_pkg::t_side                  o_side
);

    localparam int NS = pwmpde_pkg::DIV_STAGES;
    localparam int NW = pwmpde_pkg::NUM_W;
    localparam int QW = pwmpde_pkg::QUO_W;

    logic [NS-1:0]      r_valid;
    logic [NW-1:0]      r_rem  [NS];
    logic [QW-1:0]      r_nq   [NS];
    logic [NW-1:0]      r_den  [NS];
    pwmpde_pkg::t_side  r_side [NS];

    logic [NW-1:0]      n_rem  [NS];
    logic [QW-1:0]      n_nq   [NS];
    logic [NS:0]        en;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[NS-1];
    assign o_quo   = r_nq[NS-1];
    assign o_side  = r_side[NS-1];

    // quotient bits shift into the low end while numerator bits leave the top
    always_comb begin
        logic [NW:0]   t;
        logic [NW-1:0] rem;
        logic [QW-1:0] nq;
        logic [NW-1:0] den;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rem = NW'(i_num[NW-1]);
                nq  = i_num[QW-1:0];
                den = i_den;
            end else begin
                rem = r_rem[(k == 0) ? 0 : k - 1];
                nq  = r_nq[(k == 0) ? 0 : k - 1];
                den = r_den[(k == 0) ? 0 : k - 1];
            end
            for (int j = 0; j < pwmpde_pkg::DIV_STEP; j++) begin
                t  = {rem, nq[QW-1]};
                nq = {nq[QW-2:0], 1'b0};
                if (t >= {1'b0, den}) begin
                    rem   = NW'(t - {1'b0, den});
                    nq[0] = 1'b1;
                end else begin
                    rem = t[NW-1:0];
                end
            end
            n_rem[k] = rem;
            n_nq[k]  = nq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= n_rem[0];
            r_nq[0]   <= n_nq[0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pwmpde_shift.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwmpde_shift
// Prescale shift selection and period word rounding, three stages.
// ============================================================================
module pwmpde_shift (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [pwmpde_pkg::QUO_W-1:0]  i_quo,
    input  wire pwmpde_pkg::t_side             i_side,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output pwmpde_pkg::t_per                   o_per
);

    localparam int QW = pwmpde_pkg::QUO_W;
    localparam int SW = pwmpde_pkg::SHIFT_W;
    localparam int TW = pwmpde_pkg::TOP_W;
    localparam int NW = pwmpde_pkg::NUM_W;

    function automatic logic [SW-1:0] low_zeros(input logic [QW-1:0] v);
        logic [SW-1:0] n;
        n = '0;
        for (int i = QW - 1; i >= 0; i--) begin
            if (v[i]) n = SW'(i);
        end
        return n;
    endfunction

    function automatic logic [TW-1:0] bit_len(input logic [QW-1:0] v);
        logic [TW-1:0] n;
        n = '0;
        for (int i = 0; i < QW; i++) begin
            if (v[i]) n = TW'(i + 1);
        end
        return n;
    endfunction

    logic [2:0]         r_valid;
    logic [2:0]         en;

    logic [QW-1:0]      r1_div;
    logic [SW-1:0]      r1_shift;
    pwmpde_pkg::t_side  r1_side;
    logic [QW-1:0]      r2_div;
    logic [SW-1:0]      r2_shift;
    pwmpde_pkg::t_side  r2_side;
    pwmpde_pkg::t_per   r3_per;

    logic [QW-1:0]      n1_div;
    logic [SW-1:0]      n1_tz;
    logic [SW-1:0]      n1_shift;
    logic [TW-1:0]      n2_top;
    logic [SW-1:0]      n2_shift;
    logic [NW-1:0]      n3_rnd;

    always_comb begin
        en[2] = !r_valid[2] || i_ready;
        en[1] = !r_valid[1] || en[2];
        en[0] = !r_valid[0] || en[1];
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[2];
    assign o_per   = r3_per;

    always_comb begin
        n1_div   = (i_quo == '0) ? QW'(1) : i_quo;
        n1_tz    = low_zeros(n1_div);
        n1_shift = (n1_tz < pwmpde_pkg::FORCE_SHIFT && n1_div >= pwmpde_pkg::FORCE_DIV)
                   ? pwmpde_pkg::FORCE_SHIFT : n1_tz;
    end

    // widen until the shifted divider fits the period word
    always_comb begin
        n2_top = bit_len(r1_div >> r1_shift);
        if (n2_top > TW'(pwmpde_pkg::PER_W)) begin
            n2_shift = r1_shift + SW'(n2_top - TW'(pwmpde_pkg::PER_W));
        end else begin
            n2_shift = r1_shift;
        end
    end

    always_comb begin
        n3_rnd = {1'b0, r2_div};
        if (r2_shift != '0) begin
            n3_rnd = n3_rnd + (NW'(1) << (r2_shift - SW'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) r_valid[0] <= i_valid;
            if (en[1]) r_valid[1] <= r_valid[0];
            if (en[2]) r_valid[2] <= r_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_div   <= n1_div;
            r1_shift <= n1_shift;
            r1_side  <= i_side;
        end
        if (en[1]) begin
            r2_div   <= r1_div;
            r2_shift <= n2_shift;
            r2_side  <= r1_side;
        end
        if (en[2]) begin
            r3_per.period    <= pwmpde_pkg::PER_W'((n3_rnd >> r2_shift) - NW'(1));
            r3_per.shift     <= r2_shift;
            r3_per.cmode     <= (r2_shift == '0);
            r3_per.duty      <= r2_side.duty;
            r3_per.freq_zero <= r2_side.freq_zero;
        end
    end

endmodule
`default_nettype wire

[rtl/pwmpde_duty.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwmpde_duty
// Duty word scaling by reciprocal multiply, saturation and flag merge.
// ============================================================================
module pwmpde_duty (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire pwmpde_pkg::t_per  i_per,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pwmpde_pkg::t_res       o_res
);

    localparam int XW = pwmpde_pkg::X_W;
    localparam int YW = pwmpde_pkg::Y_W;
    localparam int MW = pwmpde_pkg::M_W;
    localparam int PW = pwmpde_pkg::PROD_W;
    localparam int WW = pwmpde_pkg::PER_W;

    logic [4:0]        r_valid;
    logic [4:0]        en;
    pwmpde_pkg::t_per  r_per [4];

    logic [XW-1:0]     r1_x;
    logic              r1_use;
    logic              r1_derr;
    logic [YW-1:0]     r2_y;
    logic              r2_use;
    logic              r2_derr;
    logic              r2_clip;
    logic [PW-1:0]     r3_prod;
    logic [YW-1:0]     r3_y;
    logic              r3_use;
    logic              r3_derr;
    logic              r3_clip;
    logic [WW-1:0]     r4_qe;
    logic [YW-1:0]     r4_qw;
    logic [YW-1:0]     r4_y;
    logic              r4_use;
    logic              r4_derr;
    logic              r4_clip;
    pwmpde_pkg::t_res  r5_res;

    logic              n1_derr;
    logic [WW-1:0]     n4_qe;
    logic [YW-1:0]     n5_rem;
    logic [WW-1:0]     n5_q;

    always_comb begin
        en[4] = !r_valid[4] || i_ready;
        for (int k = 3; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[4];
    assign o_res   = r5_res;

    assign n1_derr = i_per.duty > pwmpde_pkg::DUTY_W'(pwmpde_pkg::WIDTH_MAX);
    assign n4_qe   = r3_prod[pwmpde_pkg::RECIP_SH +: WW];
    // estimate is exact or one short
    assign n5_rem  = r4_y - r4_qw;
    assign n5_q    = (n5_rem >= YW'(pwmpde_pkg::WIDTH_MAX)) ? r4_qe + WW'(1) : r4_qe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) r_valid[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                if (en[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_per[0] <= i_per;
            r1_x     <= XW'(i_per.duty) << i_per.shift;
            r1_derr  <= n1_derr;
            r1_use   <= !i_per.cmode && !n1_derr && !i_per.freq_zero;
        end
        if (en[1]) begin
            r_per[1] <= r_per[0];
            r2_clip  <= r1_use && (r1_x >= pwmpde_pkg::CLIP_X);
            r2_y     <= r1_x[YW-1:0] + YW'(pwmpde_pkg::HALF_W);
            r2_use   <= r1_use;
            r2_derr  <= r1_derr;
        end
        if (en[2]) begin
            r_per[2] <= r_per[1];
            r3_prod  <= {{MW{1'b0}}, r2_y} * {{YW{1'b0}}, pwmpde_pkg::RECIP_M};
            r3_y     <= r2_y;
            r3_use   <= r2_use;
            r3_derr  <= r2_derr;
            r3_clip  <= r2_clip;
        end
        if (en[3]) begin
            r_per[3] <= r_per[2];
            r4_qe    <= n4_qe;
            r4_qw    <= YW'(n4_qe) * YW'(pwmpde_pkg::WIDTH_MAX);
            r4_y     <= r3_y;
            r4_use   <= r3_use;
            r4_derr  <= r3_derr;
            r4_clip  <= r3_clip;
        end
        if (en[4]) begin
            r5_res.period <= r_per[3].freq_zero ? '0 : r_per[3].period;
            r5_res.shift  <= r_per[3].freq_zero ? '0 : r_per[3].shift;
            r5_res.cmode  <= r_per[3].cmode && !r_per[3].freq_zero;
            r5_res.derr   <= r4_derr;
            r5_res.ferr   <= r_per[3].freq_zero;
            r5_res.clip   <= r4_use && r4_clip;
            if (!r4_use) begin
                r5_res.dword <= '0;
            end else if (r4_clip) begin
                r5_res.dword <= pwmpde_pkg::WORD_MAX;
            end else begin
                r5_res.dword <= n5_q;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pwm_period_duty_encoder_unit.sv]
// Pipeline: 16 divider stages, 3 shift/period stages, 5 duty scaling stages.
// Throughput: one transaction per cycle unless the sink stalls; the 33-bit
// restoring divider retires 2 quotient bits per stage, so a new item enters
// every clock while the pipe is not stalled.
// Back-pressure ripples stage by stage, so empty stages still accept input.
// Reset (synchronous, active low) empties the pipe; clock rate = 156000000.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwm_period_duty_encoder_unit
// Converts frequency / duty requests into PWM period, prescale and duty words.
// ============================================================================
module pwm_period_duty_encoder_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration: counter clock rate in Hz
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [pwmpde_pkg::RATE_W-1:0]          i_cfg_data,
    // request stream
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // [31:0] req_freq_hz, [47:32] req_duty
    input  wire logic [pwmpde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [15:0] period_word, [20:16] prescale_shift, [36:21] duty_word, rest 0
    output logic [pwmpde_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // [0] clock_mode, [1] duty_error, [2] freq_error, [3] duty_clipped
    output logic [pwmpde_pkg::OUT_TUSER_W-1:0]          m_axis_tuser
);

    localparam int NW = pwmpde_pkg::NUM_W;
    localparam int FW = pwmpde_pkg::FREQ_W;

    logic [pwmpde_pkg::RATE_W-1:0]  r_clock_rate;

    logic [FW-1:0]                  freq;
    logic [NW-1:0]                  num;
    logic [NW-1:0]                  den;
    pwmpde_pkg::t_side              side;

    logic                           div_valid;
    logic                           div_ready;
    logic [pwmpde_pkg::QUO_W-1:0]   div_quo;
    pwmpde_pkg::t_side              div_side;
    logic                           sh_valid;
    logic                           sh_ready;
    pwmpde_pkg::t_per               sh_per;
    pwmpde_pkg::t_res               res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= pwmpde_pkg::CLK_RATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clock_rate <= i_cfg_data;
        end
    end

    assign freq           = s_axis_tdata[FW-1:0];
    assign side.duty      = s_axis_tdata[FW +: pwmpde_pkg::DUTY_W];
    assign side.freq_zero = (freq == '0);
    // rounded half period: (clk + f) / (2 f), full width
    assign num = NW'(r_clock_rate) + NW'(freq);
    assign den = {freq, 1'b0};

    pwmpde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_num   (num),
        .i_den   (den),
        .i_side  (side),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    pwmpde_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_quo   (div_quo),
        .i_side  (div_side),
        .o_valid (sh_valid),
        .i_ready (sh_ready),
        .o_per   (sh_per)
    );

    pwmpde_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sh_valid),
        .o_ready (sh_ready),
        .i_per   (sh_per),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = pwmpde_pkg::OUT_TDATA_W'({res.dword, res.shift, res.period});
    assign m_axis_tuser = {res.clip, res.ferr, res.derr, res.cmode};

    // zero frequency blanks every word
    a_ferr_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.ferr |-> res.period == '0 && res.shift == '0
                                      && res.dword == '0 && !res.cmode && !res.clip)
        else $error("freq error with nonzero words");

    a_cmode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.cmode |-> res.shift == '0 && res.dword == '0 && !res.clip)
        else $error("clock mode with nonzero shift or duty");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.clip |-> res.dword == pwmpde_pkg::WORD_MAX && !res.derr)
        else $error("clipped duty not saturated");

    // input stalls only when the whole pipe is full and the sink holds off
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

[tb/sv/pwm_period_duty_encoder_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// pwm_period_duty_encoder_unit_tb
// Self-checking bench: streams frequency / duty requests under several counter
// clock rates, predicts period, prescale and duty words in a scoreboard and
// checks each result transaction in order, with random stalls on both sides.
// ============================================================================
module pwm_period_duty_encoder_unit_tb;
    import pwmpde_pkg::*;

    localparam int unsigned FULL_SCALE     = 10000;
    localparam logic [63:0] FLOOR_DIV      = 64'h0f00;
    localparam int unsigned FLOOR_SHIFT    = 8;
    localparam int unsigned PERIOD_BITS    = 16;
    localparam logic [63:0] WORD_CAP       = 64'hffff;
    localparam logic [31:0] RATE_AT_RESET  = 32'd156000000;
    localparam int unsigned PIPE_LATENCY   = 24;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned STALL_LIMIT    = 3000;

    // result tdata layout
    localparam int PER_LSB   = 0;
    localparam int SHIFT_LSB = 16;
    localparam int DWORD_LSB = 21;
    localparam int PAD_LSB   = 37;

    class pwm_word_scoreboard;
        logic [31:0] clk_rate;
        t_res        pending_words[$];
        int unsigned errors;

        function new();
            clk_rate = RATE_AT_RESET;
            errors   = 0;
        endfunction

        function t_res encode(logic [31:0] freq, logic [15:0] duty);
            t_res            r;
            logic [63:0]     dv;
            logic [63:0]     dw;
            logic [63:0]     tmp;
            int unsigned     sh;
            int unsigned     top;
            r = '0;
            r.derr = (duty > FULL_SCALE);
            if (freq == 0) begin
                r.ferr = 1'b1;
                return r;
            end
            dv = (64'(clk_rate) + 64'(freq)) / (64'(freq) << 1);
            if (dv == 0)
                dv = 64'd1;
            sh = 0;
            while (!dv[sh])
                sh++;
            if (sh < FLOOR_SHIFT && dv >= FLOOR_DIV)
                sh = FLOOR_SHIFT;
            tmp = dv >> sh;
            top = 0;
            while (tmp != 0) begin
                tmp = tmp >> 1;
                top++;
            end
            if (top > PERIOD_BITS)
                sh += top - PERIOD_BITS;
            if (sh > 0)
                dv = (dv + (64'd1 << (sh - 1))) >> sh;
            dv = dv - 64'd1;
            r.period = dv[15:0];
            r.shift  = 5'(sh);
            r.cmode  = (sh == 0);
            if (!r.cmode && !r.derr) begin
                dw = ((64'(duty) << sh) + 64'(FULL_SCALE / 2)) / 64'(FULL_SCALE);
                if (dw > WORD_CAP) begin
                    dw     = WORD_CAP;
                    r.clip = 1'b1;
                end
                r.dword = dw[15:0];
            end
            return r;
        endfunction

        function void note_request(logic [31:0] freq, logic [15:0] duty);
            pending_words.push_back(encode(freq, duty));
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data,
                                   logic [OUT_TUSER_W-1:0] user);
            t_res want;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                         $time, data, user);
                return;
            end
            want = pending_words.pop_front();
            compare("period_word", want.period, data[SHIFT_LSB-1:PER_LSB]);
            compare("prescale_shift", want.shift, data[DWORD_LSB-1:SHIFT_LSB]);
            compare("duty_word", want.dword, data[PAD_LSB-1:DWORD_LSB]);
            compare("tdata padding", 0, data[OUT_TDATA_W-1:PAD_LSB]);
            compare("clock_mode", want.cmode, user[U_CMODE]);
            compare("duty_error", want.derr, user[U_DERR]);
            compare("freq_error", want.ferr, user[U_FERR]);
            compare("duty_clipped", want.clip, user[U_CLIP]);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [RATE_W-1:0]         i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [OUT_TUSER_W-1:0]    m_axis_tuser;

    pwm_word_scoreboard words = new();
    bit                 steady;
    bit                 hold_pending;
    int unsigned        quiet_cycles = 0;

    pwm_period_duty_encoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly no gap, some short, a few long; none while steady
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_freq();
        longint unsigned span;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2, 3: begin
                // aim the divider near a chosen value
                span = 64'($urandom_range(1, 70000));
                return 32'(64'(words.clk_rate) / (2 * span));
            end
            4: begin
                // divider with many trailing zeros
                span = 64'($urandom_range(1, 255)) << $urandom_range(0, 16);
                return 32'(64'(words.clk_rate) / (2 * span));
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [15:0] rand_duty();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(FULL_SCALE + 1, 16'hffff));
            1: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return 16'(FULL_SCALE);
                    2:       return 16'(FULL_SCALE + 1);
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    task automatic send_request(input logic [31:0] freq, input logic [15:0] duty);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {duty, freq};
        do @(posedge i_clk); while (!s_axis_tready);
        words.note_request(freq, duty);
    endtask

    task automatic random_requests(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n > 0 && n % 60 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_request(rand_freq(), rand_duty());
        end
    endtask

    // sender stops until every result is back, then the pipe settles
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (words.outstanding() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 6) @(posedge i_clk);
    endtask

    task automatic set_clock_rate(input logic [31:0] rate);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        words.clk_rate = rate;
    endtask

    // result receiver
    initial begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            words.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("pwm_period_duty_encoder_unit_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] rate_pick;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        hold_pending  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset clock rate: zero frequency, duty limits, clock mode, prescale floor
        send_request(32'd0, 16'd0);
        send_request(32'd0, 16'd10001);
        send_request(32'd1, 16'd0);
        send_request(32'd1, 16'd10000);
        send_request(32'd1, 16'd10001);
        send_request(32'd1, 16'hffff);
        send_request(32'hffff_ffff, 16'd5000);
        send_request(32'd78000000, 16'd5000);
        send_request(32'd39000000, 16'd9999);
        send_request(32'd20313, 16'd10000);
        send_request(32'd20318, 16'd1);
        send_request(32'd40625, 16'd5000);
        send_request(32'd1000, 16'd1);
        send_request(32'd50000, 16'd5000);
        send_request(32'd2380, 16'd7777);
        send_request(32'd1190, 16'd10000);
        random_requests(100);
        drain();
        random_requests(100);
        drain();

        // top clock rate: widest shift, duty saturation
        set_clock_rate(32'hffff_ffff);
        send_request(32'd1, 16'd10000);
        send_request(32'd1, 16'd5000);
        send_request(32'd1, 16'd1);
        send_request(32'd2, 16'd0);
        send_request(32'd3, 16'd9999);
        send_request(32'hffff_ffff, 16'd10000);
        send_request(32'h8000_0000, 16'd10000);
        steady       = 1'b1;
        hold_pending = 1'b1;
        random_requests(150);
        drain();

        // lowest clock rate: divider always 1
        set_clock_rate(32'd1);
        steady = 1'b0;
        random_requests(40);
        drain();

        repeat (4) begin
            rate_pick = $urandom >> $urandom_range(0, 24);
            if (rate_pick == 0)
                rate_pick = 32'd1;
            set_clock_rate(rate_pick);
            random_requests(70);
            drain();
        end

        set_clock_rate(RATE_AT_RESET);
        random_requests(50);
        drain();

        if (words.errors == 0 && words.outstanding() == 0) begin
            $display("pwm_period_duty_encoder_unit_tb OK");
        end else begin
            $display("pwm_period_duty_encoder_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
